@@ rtl/core/gpps_pkg.sv @@
// Types, codes and constants shared by the game pad poll sequencer.
// No dependencies.
package gpps_pkg;

   localparam int MAX_REPLY_BYTES = 8;
   localparam int IDX_W = $clog2(MAX_REPLY_BYTES);
   localparam int LEN_W = $clog2(MAX_REPLY_BYTES + 1);
   localparam int RAW_LEN_W = 6;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_RX    = 2'd1;
   localparam logic [1:0] MODE_ACK   = 2'd2;
   localparam logic [1:0] MODE_TICK  = 2'd3;

   localparam logic [1:0] ST_COMPLETE   = 2'd0;
   localparam logic [1:0] ST_NO_DEVICE  = 2'd1;
   localparam logic [1:0] ST_NO_ACK_HDR = 2'd2;
   localparam logic [1:0] ST_ACK_LOST   = 2'd3;

   localparam logic [1:0] CSR_SETTLE = 2'd0;
   localparam logic [1:0] CSR_ACK_TO = 2'd1;
   localparam logic [1:0] CSR_RX_TO  = 2'd2;

   localparam logic [7:0]  CMD_START  = 8'h01;
   localparam logic [7:0]  CMD_POLL   = 8'h42;
   localparam logic [7:0]  CMD_IDLE   = 8'h00;
   localparam logic [7:0]  RX_MISSING = 8'hFF;
   localparam logic [7:0]  AXIS_REST  = 8'h80;
   localparam logic [3:0]  KIND_ANALOG_A = 4'h5;
   localparam logic [3:0]  KIND_ANALOG_B = 4'h7;
   localparam logic [15:0] BUTTON_INV = 16'hFFFF;

   localparam logic [7:0]  SETTLE_RESET = 8'd6;
   localparam logic [9:0]  ACK_TO_RESET = 10'd50;
   localparam logic [15:0] RX_TO_RESET  = 16'd100;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETTLE,
      PH_ACK_FIRST,
      PH_RX,
      PH_ACK_BYTE,
      PH_END
   } gpps_phase_type;

   typedef logic [MAX_REPLY_BYTES-1:0][7:0] gpps_reply_type;

   typedef struct packed {
      logic [7:0]  settle_ticks;
      logic [9:0]  ack_timeout_ticks;
      logic [15:0] rx_timeout_ticks;
   } gpps_cfg_type;

   typedef struct packed {
      logic [15:0] buttons;
      logic        is_analog;
      logic [7:0]  right_x;
      logic [7:0]  right_y;
      logic [7:0]  left_x;
      logic [7:0]  left_y;
   } gpps_res_type;

   typedef struct packed {
      logic         tx_valid;
      logic [7:0]   tx_byte;
      logic         select_active;
      logic         port_select;
      logic         done_res;
      logic [1:0]   status;
      gpps_res_type res;
   } gpps_rsp_type;

   localparam gpps_res_type RES_CLEAR = '{
      buttons: 16'h0000, is_analog: 1'b0,
      right_x: AXIS_REST, right_y: AXIS_REST, left_x: AXIS_REST, left_y: AXIS_REST
   };

   function automatic gpps_reply_type reply_init_f();
      gpps_reply_type r;
      for (int i = 0; i < MAX_REPLY_BYTES; i++) begin
         r[i] = (i < 4) ? 8'h00 : AXIS_REST;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/game_pad_poll_sequencer.sv @@
// Game pad poll sequencer top level: control registers, sequencer, result register.
// Depends on gpps_pkg and gpps_fsm.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_mode, req_port, req_rx_byte
//   rsp     | out       | rsp_valid / rsp_ready | tx, select, done, status, pad data
//   csr     | in        | csr_write             | csr_index, csr_data
//
// One event word in per cycle while ready; its result word is out the next cycle.
// req_ready drops only while a result is held and rsp_ready is low.
// Synchronous reset: idle, select off, timeouts to their defaults.
// Sequencer state advances only on an accepted word.
module game_pad_poll_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic        req_port,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_select_active,
   output logic        rsp_port_select,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_buttons,
   output logic        rsp_is_analog,
   output logic [7:0]  rsp_right_x,
   output logic [7:0]  rsp_right_y,
   output logic [7:0]  rsp_left_x,
   output logic [7:0]  rsp_left_y,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   gpps_pkg::gpps_cfg_type cfg_ff;
   gpps_pkg::gpps_rsp_type rsp_in, rsp_ff;
   logic                   rsp_valid_ff;
   logic                   accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks      <= gpps_pkg::SETTLE_RESET;
         cfg_ff.ack_timeout_ticks <= gpps_pkg::ACK_TO_RESET;
         cfg_ff.rx_timeout_ticks  <= gpps_pkg::RX_TO_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gpps_pkg::CSR_SETTLE: cfg_ff.settle_ticks      <= csr_data[7:0];
            gpps_pkg::CSR_ACK_TO: cfg_ff.ack_timeout_ticks <= csr_data[9:0];
            gpps_pkg::CSR_RX_TO:  cfg_ff.rx_timeout_ticks  <= csr_data;
            default: ;
         endcase
      end
   end

   gpps_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .mode    (req_mode),
      .port    (req_port),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_valid      = rsp_ff.tx_valid;
   assign rsp_tx_byte       = rsp_ff.tx_byte;
   assign rsp_select_active = rsp_ff.select_active;
   assign rsp_port_select   = rsp_ff.port_select;
   assign rsp_done_res      = rsp_ff.done_res;
   assign rsp_status        = rsp_ff.status;
   assign rsp_buttons       = rsp_ff.res.buttons;
   assign rsp_is_analog     = rsp_ff.res.is_analog;
   assign rsp_right_x       = rsp_ff.res.right_x;
   assign rsp_right_y       = rsp_ff.res.right_y;
   assign rsp_left_x        = rsp_ff.res.left_x;
   assign rsp_left_y        = rsp_ff.res.left_y;

endmodule

@@ rtl/core/gpps_fsm.sv @@
// Poll sequencer state and next-state logic: one event per accepted word.
// Depends on gpps_pkg.
module gpps_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           mode,
   input  logic                 port,
   input  logic [7:0]           rx_byte,
   input  gpps_pkg::gpps_cfg_type cfg,
   output gpps_pkg::gpps_rsp_type rsp
);

   gpps_pkg::gpps_phase_type phase_ff, phase_in;
   logic [15:0]                  timer_ff, timer_in;
   gpps_pkg::gpps_reply_type     bytes_ff, bytes_in;
   logic [gpps_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [gpps_pkg::LEN_W-1:0]   len_ff, len_in;
   gpps_pkg::gpps_res_type       res_ff, res_in;
   logic                         latch_ff, latch_in;
   logic                         sel_ff, sel_in;
   logic                         port_ff, port_in;
   logic [1:0]                   end_ff, end_in;

   logic                         tick;
   logic                         store, begin_rx, send_first, do_decode, end_req, fin;
   logic [7:0]                   store_val;
   logic [gpps_pkg::IDX_W-1:0]   begin_idx;
   logic [1:0]                   end_code, fin_code;
   logic [gpps_pkg::RAW_LEN_W-1:0] raw_len;
   logic [3:0]                   kind;

   assign tick = (mode == gpps_pkg::MODE_TICK);

   always_comb begin
      phase_in   = phase_ff;
      timer_in   = tick ? timer_ff + 16'd1 : timer_ff;
      bytes_in   = bytes_ff;
      idx_in     = idx_ff;
      len_in     = len_ff;
      res_in     = res_ff;
      latch_in   = latch_ff;
      sel_in     = sel_ff;
      port_in    = port_ff;
      end_in     = end_ff;
      store      = 1'b0;
      store_val  = rx_byte;
      begin_rx   = 1'b0;
      begin_idx  = '0;
      send_first = 1'b0;
      do_decode  = 1'b0;
      end_req    = 1'b0;
      end_code   = gpps_pkg::ST_COMPLETE;
      fin        = 1'b0;
      fin_code   = gpps_pkg::ST_COMPLETE;
      raw_len    = '0;
      kind       = '0;
      rsp.tx_valid = 1'b0;
      rsp.tx_byte  = gpps_pkg::CMD_IDLE;
      rsp.done_res = 1'b0;
      rsp.status   = gpps_pkg::ST_COMPLETE;

      unique case (phase_ff)
         gpps_pkg::PH_IDLE: begin
            timer_in = '0;
            if (mode == gpps_pkg::MODE_START) begin
               res_in   = gpps_pkg::RES_CLEAR;
               bytes_in = gpps_pkg::reply_init_f();
               port_in  = port;
               sel_in   = 1'b1;
               latch_in = 1'b0;
               idx_in   = '0;
               len_in   = '0;
               end_in   = gpps_pkg::ST_COMPLETE;
               phase_in = gpps_pkg::PH_SETTLE;
               if (cfg.settle_ticks == 8'd0) send_first = 1'b1;
            end
         end
         gpps_pkg::PH_SETTLE: begin
            if (tick && timer_in >= {8'd0, cfg.settle_ticks}) send_first = 1'b1;
         end
         gpps_pkg::PH_ACK_FIRST: begin
            if (mode == gpps_pkg::MODE_ACK) begin
               begin_rx = 1'b1;
            end else if (tick && timer_in >= {6'd0, cfg.ack_timeout_ticks}) begin
               fin      = 1'b1;
               fin_code = gpps_pkg::ST_NO_DEVICE;
            end
         end
         gpps_pkg::PH_RX: begin
            if (mode == gpps_pkg::MODE_RX) begin
               store = 1'b1;
            end else if (mode == gpps_pkg::MODE_ACK) begin
               latch_in = 1'b1;
            end else if (tick && timer_in >= cfg.rx_timeout_ticks) begin
               store     = 1'b1;
               store_val = gpps_pkg::RX_MISSING;
            end
         end
         gpps_pkg::PH_ACK_BYTE: begin
            if (mode == gpps_pkg::MODE_ACK) begin
               begin_rx  = 1'b1;
               begin_idx = idx_ff + 1'b1;
            end else if (tick && timer_in >= {6'd0, cfg.ack_timeout_ticks}) begin
               end_req = 1'b1;
               if (idx_ff == '0) begin
                  end_code = gpps_pkg::ST_NO_ACK_HDR;
               end else begin
                  do_decode = 1'b1;
                  end_code  = gpps_pkg::ST_ACK_LOST;
               end
            end
         end
         gpps_pkg::PH_END: begin
            if (tick && timer_in >= {8'd0, cfg.settle_ticks}) begin
               fin      = 1'b1;
               fin_code = end_ff;
            end
         end
         default: begin
            phase_in = gpps_pkg::PH_IDLE;
            sel_in   = 1'b0;
         end
      endcase

      // reply byte stored: header sets the length, last byte ends the exchange
      if (store) begin
         bytes_in[idx_ff] = store_val;
         if (idx_ff == '0) begin
            raw_len = ({2'b00, store_val[3:0]} + 6'd1) << 1;
            if (raw_len > gpps_pkg::RAW_LEN_W'(gpps_pkg::MAX_REPLY_BYTES))
               len_in = gpps_pkg::LEN_W'(gpps_pkg::MAX_REPLY_BYTES);
            else
               len_in = raw_len[gpps_pkg::LEN_W-1:0];
         end
         if (idx_ff != '0 &&
             (gpps_pkg::LEN_W'(idx_ff) + gpps_pkg::LEN_W'(1)) >= len_ff) begin
            do_decode = 1'b1;
            end_req   = 1'b1;
            end_code  = gpps_pkg::ST_COMPLETE;
         end else begin
            timer_in = '0;
            phase_in = gpps_pkg::PH_ACK_BYTE;
            if (latch_ff) begin
               latch_in  = 1'b0;
               begin_rx  = 1'b1;
               begin_idx = idx_ff + 1'b1;
            end
         end
      end

      if (begin_rx) begin
         idx_in       = begin_idx;
         timer_in     = '0;
         phase_in     = gpps_pkg::PH_RX;
         rsp.tx_valid = 1'b1;
         rsp.tx_byte  = (begin_idx == '0) ? gpps_pkg::CMD_POLL : gpps_pkg::CMD_IDLE;
         latch_in     = 1'b0;
      end

      if (send_first) begin
         rsp.tx_valid = 1'b1;
         rsp.tx_byte  = gpps_pkg::CMD_START;
         latch_in     = 1'b0;
         timer_in     = '0;
         phase_in     = gpps_pkg::PH_ACK_FIRST;
      end

      if (do_decode) begin
         kind = bytes_in[0][7:4];
         res_in.buttons = {bytes_in[3], bytes_in[2]} ^ gpps_pkg::BUTTON_INV;
         if (kind == gpps_pkg::KIND_ANALOG_A || kind == gpps_pkg::KIND_ANALOG_B) begin
            res_in.is_analog = 1'b1;
            res_in.right_x   = bytes_in[4];
            res_in.right_y   = bytes_in[5];
            res_in.left_x    = bytes_in[6];
            res_in.left_y    = bytes_in[7];
         end
      end

      if (end_req) begin
         end_in   = end_code;
         timer_in = '0;
         phase_in = gpps_pkg::PH_END;
         if (cfg.settle_ticks == 8'd0) begin
            fin      = 1'b1;
            fin_code = end_code;
         end
      end

      if (fin) begin
         sel_in       = 1'b0;
         phase_in     = gpps_pkg::PH_IDLE;
         timer_in     = '0;
         rsp.done_res = 1'b1;
         rsp.status   = fin_code;
      end

      rsp.select_active = sel_in;
      rsp.port_select   = port_in;
      rsp.res           = res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gpps_pkg::PH_IDLE;
         timer_ff <= '0;
         bytes_ff <= gpps_pkg::reply_init_f();
         idx_ff   <= '0;
         len_ff   <= '0;
         res_ff   <= gpps_pkg::RES_CLEAR;
         latch_ff <= 1'b0;
         sel_ff   <= 1'b0;
         port_ff  <= 1'b0;
         end_ff   <= gpps_pkg::ST_COMPLETE;
      end else if (accept) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         bytes_ff <= bytes_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         res_ff   <= res_in;
         latch_ff <= latch_in;
         sel_ff   <= sel_in;
         port_ff  <= port_in;
         end_ff   <= end_in;
      end
   end

endmodule

@@ rtl/core/gpps_checker.sv @@
// Port-level checks for the game pad poll sequencer, bound to the top level.
// Depends on game_pad_poll_sequencer.
module gpps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_tx_valid,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_select_active,
   input logic        rsp_done_res,
   input logic [1:0]  rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_status))
      else $error("result word changed while stalled");

   a_ready_only_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("event word refused without a stalled result");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted event produced no result word");

   a_done_drops_select: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_select_active && !rsp_tx_valid)
      else $error("poll ended with select held or a byte sent");

endmodule

bind game_pad_poll_sequencer gpps_checker u_gpps_checker (.*);
